@@ rtl/spo_pkg.sv @@
// Shared types, constants and the sine table builder for the sine phase oscillator.
`default_nettype none

package spo_pkg;

    // Default geometry of the oscillator.
    localparam int PHASE_BITS_DEF      = 32;
    localparam int TABLE_ADDR_BITS_DEF = 10;
    localparam int SAMPLE_BITS_DEF     = 16;

    // Fixed field and register widths.
    localparam int START_BITS     = 32;
    localparam int TUNING_BITS    = 32;
    localparam int GAIN_BITS      = 15;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    // Register indexes on the configuration port.
    localparam logic [CFG_INDEX_BITS-1:0] REG_TUNING_WORD = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN        = 2'd1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 15'd32767;

    // pi/2 in Q30.
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    // Rounded-up reciprocals of the Taylor divisors (2n)(2n+1), scaled by
    // 2^48. Every term stays far below 2^40, so multiplying by these and
    // shifting down gives the exact truncated quotient.
    localparam int              RECIP_SHIFT      = 48;
    localparam longint unsigned TAYLOR_RECIP [7] = '{
        ((64'd1 << RECIP_SHIFT) + 64'd5)   / 64'd6,
        ((64'd1 << RECIP_SHIFT) + 64'd19)  / 64'd20,
        ((64'd1 << RECIP_SHIFT) + 64'd41)  / 64'd42,
        ((64'd1 << RECIP_SHIFT) + 64'd71)  / 64'd72,
        ((64'd1 << RECIP_SHIFT) + 64'd109) / 64'd110,
        ((64'd1 << RECIP_SHIFT) + 64'd155) / 64'd156,
        ((64'd1 << RECIP_SHIFT) + 64'd209) / 64'd210
    };

    // One frame request as it waits in the queue.
    typedef struct packed {
        logic                  jump;
        logic [START_BITS-1:0] start_index;
        logic                  block_last;
    } t_item;

    // Head of the request queue as seen by the back end.
    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    // One quarter-wave table entry, worked out at elaboration time from a
    // Q30 Taylor series of sin(x) up to the x^15 term.
    function automatic longint unsigned sine_entry(
        input longint unsigned k,
        input int              addr_bits,
        input longint          full_scale
    );
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        logic [127:0]    prod;
        x    = (k * HALF_PI_Q30) >> addr_bits;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            prod = 128'(term) * 128'(TAYLOR_RECIP[n - 1]);
            term = 64'(prod >> RECIP_SHIFT);
            if ((n % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (64'sd1 <<< 30)) begin
            sum = 64'sd1 <<< 30;
        end
        return longint'((sum * full_scale + (64'sd1 <<< 29)) >>> 30);
    endfunction

endpackage

`default_nettype wire

@@ rtl/spo_req_if.sv @@
// Request channel of the sine phase oscillator: one audio frame per request.
`default_nettype none

interface spo_req_if
    import spo_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic                  jump;
    logic [START_BITS-1:0] start_index;
    logic                  block_last;

    modport source (output valid, output jump, output start_index, output block_last,
                    input ready);
    modport sink   (input valid, input jump, input start_index, input block_last,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/spo_rsp_if.sv @@
// Result channel of the sine phase oscillator: one sample per request.
`default_nettype none

interface spo_rsp_if
    import spo_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          block_end;

    modport source (output valid, output sample, output block_end, input ready);
    modport sink   (input valid, input sample, input block_end, output ready);
endinterface

`default_nettype wire

@@ rtl/spo_front.sv @@
// Front end: takes requests and holds them in a short queue for the back end.
`default_nettype none

module spo_front
    import spo_pkg::*;
(
    input  wire         i_clk,
    input  wire         i_rst_n,
    spo_req_if.sink     i_req,
    output t_queue_head o_head,
    input  wire         i_pop
);

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    t_item                r_queue [QUEUE_DEPTH];
    logic [PTR_BITS-1:0]  r_wr_ptr;
    logic [PTR_BITS-1:0]  r_rd_ptr;
    logic [CNT_BITS-1:0]  r_count;
    logic                 n_push;
    logic                 n_pop;
    t_item                n_item;

    // Capture the request fields; a seek is flagged by jump alone.
    always_comb begin
        n_item.jump        = i_req.jump;
        n_item.start_index = i_req.start_index;
        n_item.block_last  = i_req.block_last;
    end

    assign i_req.ready = (r_count != CNT_BITS'(QUEUE_DEPTH));
    assign n_push      = i_req.valid && i_req.ready;
    assign n_pop       = i_pop && (r_count != '0);

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_queue[r_rd_ptr];

    // Queue storage and its pointers.
    always_ff @(posedge i_clk) begin
        if (n_push) begin
            r_queue[r_wr_ptr] <= n_item;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (n_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (n_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (n_push && !n_pop) begin
                r_count <= r_count + 1'b1;
            end else if (n_pop && !n_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/spo_back.sv @@
// Back end: phase accumulator, seek multiply, sine table and gain stage.
`default_nettype none

module spo_back
    import spo_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    input  t_queue_head              i_head,
    output logic                     o_pop,
    spo_rsp_if.source                o_rsp
);

    localparam int     TBL_SIZE   = 2 ** TABLE_ADDR_BITS;
    localparam int     MAG_BITS   = SAMPLE_BITS - 1;
    localparam int     SCALE_BITS = MAG_BITS + GAIN_BITS;
    localparam longint FULL_SCALE = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;

    typedef logic [MAG_BITS-1:0] t_rom [TBL_SIZE];

    // Quarter-wave magnitudes, fixed at elaboration.
    function automatic t_rom build_rom();
        t_rom rom;
        for (int k = 0; k < TBL_SIZE; k++) begin
            rom[k] = MAG_BITS'(sine_entry(64'(k), TABLE_ADDR_BITS, FULL_SCALE));
        end
        return rom;
    endfunction

    localparam t_rom SINE_ROM = build_rom();

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEEK,
        S_LOOK,
        S_GAIN,
        S_OUT
    } t_state;

    t_state                        r_state;
    logic [TUNING_BITS-1:0]        r_tuning;
    logic [GAIN_BITS-1:0]          r_gain;
    logic [PHASE_BITS-1:0]         r_phase;
    logic [START_BITS-1:0]         r_start;
    logic                          r_last;
    logic [MAG_BITS-1:0]           r_tab;
    logic                          r_full;
    logic                          r_neg;
    logic [SCALE_BITS-1:0]         r_scaled;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_block_end;

    logic [63:0]                    n_seek_prod;
    logic [PHASE_BITS-1:0]          n_step;
    logic [TABLE_ADDR_BITS+1:0]     n_addr;
    logic [1:0]                     n_quad;
    logic [TABLE_ADDR_BITS-1:0]     n_off;
    logic [TABLE_ADDR_BITS-1:0]     n_rom_idx;
    logic [MAG_BITS-1:0]            n_mag;
    logic [MAG_BITS-1:0]            n_gained;
    logic signed [SAMPLE_BITS-1:0]  n_sample;
    logic                           n_load_out;

    // Seek multiply and the phase step, both wrapped to the phase width.
    assign n_seek_prod = 64'(r_start) * 64'(r_tuning);
    assign n_step      = PHASE_BITS'(r_tuning);

    // Table address: quadrant and offset from the top phase bits, mirrored in
    // the odd quadrants.
    assign n_addr    = r_phase[PHASE_BITS-1 -: TABLE_ADDR_BITS + 2];
    assign n_quad    = n_addr[TABLE_ADDR_BITS+1 -: 2];
    assign n_off     = n_addr[TABLE_ADDR_BITS-1:0];
    assign n_rom_idx = n_quad[0] ? (TABLE_ADDR_BITS'(0) - n_off) : n_off;

    // Gain stage operand and the signed result.
    assign n_mag      = r_full ? {MAG_BITS{1'b1}} : r_tab;
    assign n_gained   = r_scaled[SCALE_BITS-1 -: MAG_BITS];
    assign n_sample   = r_neg ? -$signed({1'b0, n_gained}) : $signed({1'b0, n_gained});
    assign n_load_out = !r_out_valid || o_rsp.ready;

    assign o_pop = (r_state == S_IDLE) && i_head.valid;

    assign o_rsp.valid     = r_out_valid;
    assign o_rsp.sample    = r_sample;
    assign o_rsp.block_end = r_block_end;

    // Sequencer, configuration registers and the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_tuning    <= '0;
            r_gain      <= GAIN_RESET;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_head.valid) begin
                        r_start <= i_head.item.start_index;
                        r_last  <= i_head.item.block_last;
                        r_state <= i_head.item.jump ? S_SEEK : S_LOOK;
                    end
                end
                S_SEEK: begin
                    r_phase <= PHASE_BITS'(n_seek_prod);
                    r_state <= S_LOOK;
                end
                S_LOOK: begin
                    r_tab   <= SINE_ROM[n_rom_idx];
                    r_full  <= n_quad[0] && (n_off == '0);
                    r_neg   <= n_quad[1];
                    r_phase <= r_phase + n_step;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_scaled <= SCALE_BITS'(n_mag) * SCALE_BITS'(r_gain)
                                + SCALE_BITS'(1 << (GAIN_BITS - 1));
                    r_state  <= S_OUT;
                end
                S_OUT: begin
                    if (n_load_out) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= n_sample;
                        r_block_end <= r_last;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            // The user must write registers only while the block is idle; the block does not enforce it.
            if (i_cfg_wr_en) begin
                if (i_cfg_index == REG_TUNING_WORD) begin
                    r_tuning <= TUNING_BITS'(i_cfg_data);
                    r_phase  <= '0;
                end else if (i_cfg_index == REG_GAIN) begin
                    r_gain <= GAIN_BITS'(i_cfg_data);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ rtl/sine_phase_oscillator.sv @@
// Top level of the sine phase oscillator: request queue and synthesis back end.
//
//   Channel   Direction  Handshake          Contents
//   i_req     in         valid / ready      jump, start_index, block_last
//   o_rsp     out        valid / ready      sample, block_end
//   i_cfg_*   in         write enable only  index 0 tuning word, index 1 gain
//
// Each request runs through the back-end states S_IDLE, S_LOOK, S_GAIN and
// S_OUT, with S_SEEK for the start_index by tuning word multiply when it
// seeks. The table read and the gain multiply are each registered.
// Reset is synchronous and active low; the sine table is a fixed ROM.
// A two-entry queue keeps taking requests while a sample waits on o_rsp.
`default_nettype none

module sine_phase_oscillator
    import spo_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int TABLE_ADDR_BITS = TABLE_ADDR_BITS_DEF,
    parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_wr_en,
    input  wire [CFG_INDEX_BITS-1:0] i_cfg_index,
    input  wire [CFG_DATA_BITS-1:0]  i_cfg_data,
    spo_req_if.sink                  i_req,
    spo_rsp_if.source                o_rsp
);

    t_queue_head head;
    logic        pop;

    // Request queue.
    spo_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_head  (head),
        .i_pop   (pop)
    );

    // Phase accumulator and sample generation.
    spo_back #(
        .PHASE_BITS      (PHASE_BITS),
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_head      (head),
        .o_pop       (pop),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire
